[design/tpt_pkg.sv]
// Shared types, constants and the trig table of the turtle path tracer.
`default_nettype none
package tpt_pkg;

	localparam int DIRECTIONS_DEF = 12;
	localparam int FRAC_BITS_DEF  = 16;
	localparam int POS_WIDTH_DEF  = 32;

	localparam int OUT_W      = 32;
	localparam int CFG_IDX_W  = 2;
	localparam int CFG_DATA_W = 32;
	localparam int SYM_W      = 8;
	localparam int INT_BITS   = 8;
	localparam int TRIG_W     = 31;
	localparam int TRIG_SHIFT = 30;
	localparam int TRIG_N     = 12;
	localparam int TRIG_IDX_W = 4;

	localparam logic [TRIG_W-1:0] TRIG_ONE   = 31'd1073741824;
	localparam logic [TRIG_W-1:0] TRIG_HALF  = 31'd536870912;
	localparam logic [TRIG_W-1:0] TRIG_C30   = 31'd929887697;
	localparam logic [TRIG_W-1:0] TRIG_ROUND = 31'd536870912;

	localparam logic [TRIG_IDX_W-1:0] TRIG_LAST = 4'd11;

	localparam logic [SYM_W-1:0] SYM_FWD   = 8'h66;
	localparam logic [SYM_W-1:0] SYM_A     = 8'h41;
	localparam logic [SYM_W-1:0] SYM_Z     = 8'h5A;
	localparam logic [SYM_W-1:0] SYM_LEFT  = 8'h2B;
	localparam logic [SYM_W-1:0] SYM_RIGHT = 8'h2D;

	typedef enum logic [CFG_IDX_W-1:0] {
		CFG_START_X = 2'd0,
		CFG_START_Y = 2'd1,
		CFG_STEP    = 2'd2
	} cfg_idx_t;

	typedef enum logic [1:0] {
		OP_NOP     = 2'd0,
		OP_MOVE    = 2'd1,
		OP_RESTART = 2'd2
	} op_kind_t;

	typedef struct packed {
		logic              cos_neg;
		logic [TRIG_W-1:0] cos_mag;
		logic              sin_neg;
		logic [TRIG_W-1:0] sin_mag;
	} trig_t;

	function automatic trig_t trig_lookup(input logic [TRIG_IDX_W-1:0] k);
		trig_t t;
		t = '0;
		case (k)
			4'd0:  begin t.cos_mag = TRIG_ONE;  t.sin_mag = '0;        end
			4'd1:  begin t.cos_mag = TRIG_C30;  t.sin_mag = TRIG_HALF; end
			4'd2:  begin t.cos_mag = TRIG_HALF; t.sin_mag = TRIG_C30;  end
			4'd3:  begin t.cos_mag = '0;        t.sin_mag = TRIG_ONE;  end
			4'd4:  begin t.cos_mag = TRIG_HALF; t.sin_mag = TRIG_C30;  t.cos_neg = 1'b1; end
			4'd5:  begin t.cos_mag = TRIG_C30;  t.sin_mag = TRIG_HALF; t.cos_neg = 1'b1; end
			4'd6:  begin t.cos_mag = TRIG_ONE;  t.sin_mag = '0;        t.cos_neg = 1'b1; end
			4'd7:  begin
				t.cos_mag = TRIG_C30;  t.sin_mag = TRIG_HALF;
				t.cos_neg = 1'b1;      t.sin_neg = 1'b1;
			end
			4'd8:  begin
				t.cos_mag = TRIG_HALF; t.sin_mag = TRIG_C30;
				t.cos_neg = 1'b1;      t.sin_neg = 1'b1;
			end
			4'd9:  begin t.cos_mag = '0;        t.sin_mag = TRIG_ONE;  t.sin_neg = 1'b1; end
			4'd10: begin t.cos_mag = TRIG_HALF; t.sin_mag = TRIG_C30;  t.sin_neg = 1'b1; end
			4'd11: begin t.cos_mag = TRIG_C30;  t.sin_mag = TRIG_HALF; t.sin_neg = 1'b1; end
			default: t = '0;
		endcase
		return t;
	endfunction

endpackage
`default_nettype wire

[design/turtle_path_tracer_top.sv]
// Top level of the turtle path tracer: configuration registers and the front/queue/back chain.
//
//  channel  | handshake              | payload
//  ---------+------------------------+------------------------------------------
//  cfg      | cfg_valid / cfg_ready  | cfg_index, cfg_data
//  in       | in_valid / in_ready    | action, symbol
//  out      | out_valid / out_ready  | drew, from_*, to_*, box_min_*, box_max_*
//
// One transaction per cycle sustained while out_ready holds; each input passes a queue entry, then the result register.
// The position/box update in the executor is combinational logic (add, clamp, compare) feeding its registers.
// Step deltas come from the trig table and one multiply per axis in the front end.
// Reset clears position, heading and box to zero; no clearing pass is needed.
// A two-entry queue decouples the sides: while a result waits, two more transactions
// are taken before the input stalls.
`default_nettype none
module turtle_path_tracer_top import tpt_pkg::*; #(
	parameter int DIRECTIONS = DIRECTIONS_DEF,
	parameter int FRAC_BITS  = FRAC_BITS_DEF,
	parameter int POS_WIDTH  = POS_WIDTH_DEF
) (
	input  wire logic                  clk,
	input  wire logic                  arst_n,
	input  wire logic                  cfg_valid,
	output logic                       cfg_ready,
	input  wire logic [CFG_IDX_W-1:0]  cfg_index,
	input  wire logic [CFG_DATA_W-1:0] cfg_data,
	input  wire logic                  in_valid,
	output logic                       in_ready,
	input  wire logic                  action,
	input  wire logic [SYM_W-1:0]      symbol,
	output logic                       out_valid,
	input  wire logic                  out_ready,
	output logic                       drew,
	output logic [OUT_W-1:0]           from_x,
	output logic [OUT_W-1:0]           from_y,
	output logic [OUT_W-1:0]           to_x,
	output logic [OUT_W-1:0]           to_y,
	output logic [OUT_W-1:0]           box_min_x,
	output logic [OUT_W-1:0]           box_max_x,
	output logic [OUT_W-1:0]           box_min_y,
	output logic [OUT_W-1:0]           box_max_y
);

	localparam int STEP_W = INT_BITS + FRAC_BITS;
	localparam int OP_W   = 2 * STEP_W + 4;
	localparam int CW     = (POS_WIDTH > OUT_W) ? POS_WIDTH : OUT_W;
	localparam logic signed [CW-1:0] CLAMP_MAX =
		{{(CW - POS_WIDTH + 1){1'b0}}, {(POS_WIDTH - 1){1'b1}}};
	localparam logic signed [CW-1:0] CLAMP_MIN = ~CLAMP_MAX;
	localparam logic [STEP_W-1:0] STEP_ONE = STEP_W'(1) << FRAC_BITS;

	logic signed [POS_WIDTH-1:0] start_x_q, start_y_q;
	logic [STEP_W-1:0]           step_q;
	logic                        q_push, q_full, q_pop, q_empty;
	logic [OP_W-1:0]             q_wdata, q_rdata;

	function automatic logic signed [POS_WIDTH-1:0] clamp_start(input logic [OUT_W-1:0] v);
		logic signed [CW-1:0] e;
		e = CW'($signed(v));
		if (e > CLAMP_MAX) begin
			return CLAMP_MAX[POS_WIDTH-1:0];
		end else if (e < CLAMP_MIN) begin
			return CLAMP_MIN[POS_WIDTH-1:0];
		end
		return e[POS_WIDTH-1:0];
	endfunction

	assign cfg_ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			start_x_q <= '0;
			start_y_q <= '0;
			step_q    <= STEP_ONE;
		end else if (cfg_valid) begin
			case (cfg_idx_t'(cfg_index))
				CFG_START_X: start_x_q <= clamp_start(cfg_data[OUT_W-1:0]);
				CFG_START_Y: start_y_q <= clamp_start(cfg_data[OUT_W-1:0]);
				CFG_STEP:    step_q    <= cfg_data[STEP_W-1:0];
				default: ;
			endcase
		end
	end

	tpt_front #(
		.DIRECTIONS (DIRECTIONS),
		.STEP_W     (STEP_W)
	) u_front (
		.clk         (clk),
		.arst_n      (arst_n),
		.in_valid    (in_valid),
		.in_ready    (in_ready),
		.action      (action),
		.symbol      (symbol),
		.step_length (step_q),
		.q_full      (q_full),
		.q_push      (q_push),
		.q_data      (q_wdata)
	);

	tpt_queue #(
		.W     (OP_W),
		.DEPTH (2)
	) u_queue (
		.clk       (clk),
		.arst_n    (arst_n),
		.push      (q_push),
		.push_data (q_wdata),
		.full      (q_full),
		.pop       (q_pop),
		.empty     (q_empty),
		.pop_data  (q_rdata)
	);

	tpt_back #(
		.POS_WIDTH (POS_WIDTH),
		.STEP_W    (STEP_W)
	) u_back (
		.clk       (clk),
		.arst_n    (arst_n),
		.q_empty   (q_empty),
		.q_data    (q_rdata),
		.q_pop     (q_pop),
		.start_x   (start_x_q),
		.start_y   (start_y_q),
		.out_valid (out_valid),
		.out_ready (out_ready),
		.drew      (drew),
		.from_x    (from_x),
		.from_y    (from_y),
		.to_x      (to_x),
		.to_y      (to_y),
		.box_min_x (box_min_x),
		.box_max_x (box_max_x),
		.box_min_y (box_min_y),
		.box_max_y (box_max_y)
	);

endmodule
`default_nettype wire

[design/tpt_front.sv]
// Front end: takes command transactions, tracks heading, forms scaled step deltas.
`default_nettype none
module tpt_front import tpt_pkg::*; #(
	parameter int DIRECTIONS = DIRECTIONS_DEF,
	parameter int STEP_W     = INT_BITS + FRAC_BITS_DEF
) (
	input  wire logic                clk,
	input  wire logic                arst_n,
	input  wire logic                in_valid,
	output logic                     in_ready,
	input  wire logic                action,
	input  wire logic [SYM_W-1:0]    symbol,
	input  wire logic [STEP_W-1:0]   step_length,
	input  wire logic                q_full,
	output logic                     q_push,
	output logic [2*STEP_W+3:0]      q_data
);

	localparam int HEAD_W  = $clog2(DIRECTIONS);
	localparam int PROD_W  = STEP_W + TRIG_W;
	localparam int RND_W   = PROD_W + 1;
	localparam logic [HEAD_W-1:0]     HEAD_LAST = HEAD_W'(DIRECTIONS - 1);
	localparam logic [TRIG_IDX_W-1:0] K_AT_LAST = TRIG_IDX_W'((DIRECTIONS - 1) % TRIG_N);

	logic [HEAD_W-1:0]     heading_q;
	logic [TRIG_IDX_W-1:0] k_q;
	logic                  accept;
	logic                  is_move;
	op_kind_t              kind;
	trig_t                 trig;
	logic [PROD_W-1:0]     prod_x, prod_y;
	logic [RND_W-1:0]      rnd_x, rnd_y;
	logic [STEP_W-1:0]     mag_x, mag_y;

	assign in_ready = !q_full;
	assign accept   = in_valid && in_ready;
	assign q_push   = accept;

	always_comb begin
		is_move = (symbol == SYM_FWD) || (symbol inside {[SYM_A:SYM_Z]});
		if (action) begin
			kind = OP_RESTART;
		end else if (is_move) begin
			kind = OP_MOVE;
		end else begin
			kind = OP_NOP;
		end
	end

	// k_q follows heading modulo the table size
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			heading_q <= '0;
			k_q       <= '0;
		end else if (accept) begin
			if (action) begin
				heading_q <= '0;
				k_q       <= '0;
			end else if (symbol == SYM_LEFT) begin
				if (heading_q == HEAD_LAST) begin
					heading_q <= '0;
					k_q       <= '0;
				end else begin
					heading_q <= heading_q + 1'b1;
					k_q       <= (k_q == TRIG_LAST) ? '0 : k_q + 1'b1;
				end
			end else if (symbol == SYM_RIGHT) begin
				if (heading_q == '0) begin
					heading_q <= HEAD_LAST;
					k_q       <= K_AT_LAST;
				end else begin
					heading_q <= heading_q - 1'b1;
					k_q       <= (k_q == '0) ? TRIG_LAST : k_q - 1'b1;
				end
			end
		end
	end

	// round half away from zero on magnitudes
	always_comb begin
		trig   = trig_lookup(k_q);
		prod_x = PROD_W'(step_length) * PROD_W'(trig.cos_mag);
		prod_y = PROD_W'(step_length) * PROD_W'(trig.sin_mag);
		rnd_x  = RND_W'(prod_x) + RND_W'(TRIG_ROUND);
		rnd_y  = RND_W'(prod_y) + RND_W'(TRIG_ROUND);
		mag_x  = rnd_x[TRIG_SHIFT +: STEP_W];
		mag_y  = rnd_y[TRIG_SHIFT +: STEP_W];
		q_data = {kind, trig.cos_neg, mag_x, trig.sin_neg, mag_y};
	end

	assert property (@(posedge clk) disable iff (!arst_n)
		(heading_q <= HEAD_LAST) && (k_q <= TRIG_LAST))
		else $error("heading counters out of range");

	assert property (@(posedge clk) disable iff (!arst_n)
		(heading_q == '0) |-> (k_q == '0))
		else $error("table index lost track of heading");

endmodule
`default_nettype wire

[design/tpt_queue.sv]
// Small FIFO between the front end and the executor.
`default_nettype none
module tpt_queue import tpt_pkg::*; #(
	parameter int W     = 8,
	parameter int DEPTH = 2
) (
	input  wire logic         clk,
	input  wire logic         arst_n,
	input  wire logic         push,
	input  wire logic [W-1:0] push_data,
	output logic              full,
	input  wire logic         pop,
	output logic              empty,
	output logic [W-1:0]      pop_data
);

	localparam int PTR_W = $clog2(DEPTH);
	localparam int CNT_W = $clog2(DEPTH + 1);
	localparam logic [PTR_W-1:0] PTR_LAST = PTR_W'(DEPTH - 1);
	localparam logic [CNT_W-1:0] CNT_FULL = CNT_W'(DEPTH);

	logic [W-1:0]     entries_q [DEPTH];
	logic [PTR_W-1:0] wr_ptr_q, rd_ptr_q;
	logic [CNT_W-1:0] count_q;
	logic             do_push, do_pop;

	assign full     = (count_q == CNT_FULL);
	assign empty    = (count_q == '0);
	assign do_push  = push && !full;
	assign do_pop   = pop && !empty;
	assign pop_data = entries_q[rd_ptr_q];

	always_ff @(posedge clk) begin
		if (do_push) begin
			entries_q[wr_ptr_q] <= push_data;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (do_push) begin
				wr_ptr_q <= (wr_ptr_q == PTR_LAST) ? '0 : wr_ptr_q + 1'b1;
			end
			if (do_pop) begin
				rd_ptr_q <= (rd_ptr_q == PTR_LAST) ? '0 : rd_ptr_q + 1'b1;
			end
			case ({do_push, do_pop})
				2'b10:   count_q <= count_q + 1'b1;
				2'b01:   count_q <= count_q - 1'b1;
				default: count_q <= count_q;
			endcase
		end
	end

	assert property (@(posedge clk) disable iff (!arst_n) count_q <= CNT_FULL)
		else $error("queue count overflow");

	assert property (@(posedge clk) disable iff (!arst_n) !(push && full))
		else $error("push into full queue");

endmodule
`default_nettype wire

[design/tpt_back.sv]
// Executor: applies queued operations to position and box, holds the result register.
`default_nettype none
module tpt_back import tpt_pkg::*; #(
	parameter int POS_WIDTH = POS_WIDTH_DEF,
	parameter int STEP_W    = INT_BITS + FRAC_BITS_DEF
) (
	input  wire logic                        clk,
	input  wire logic                        arst_n,
	input  wire logic                        q_empty,
	input  wire logic [2*STEP_W+3:0]         q_data,
	output logic                             q_pop,
	input  wire logic signed [POS_WIDTH-1:0] start_x,
	input  wire logic signed [POS_WIDTH-1:0] start_y,
	output logic                             out_valid,
	input  wire logic                        out_ready,
	output logic                             drew,
	output logic [OUT_W-1:0]                 from_x,
	output logic [OUT_W-1:0]                 from_y,
	output logic [OUT_W-1:0]                 to_x,
	output logic [OUT_W-1:0]                 to_y,
	output logic [OUT_W-1:0]                 box_min_x,
	output logic [OUT_W-1:0]                 box_max_x,
	output logic [OUT_W-1:0]                 box_min_y,
	output logic [OUT_W-1:0]                 box_max_y
);

	localparam int SW = ((POS_WIDTH > STEP_W) ? POS_WIDTH : STEP_W) + 2;
	localparam logic signed [SW-1:0] POS_MAX_E =
		{{(SW - POS_WIDTH + 1){1'b0}}, {(POS_WIDTH - 1){1'b1}}};
	localparam logic signed [SW-1:0] POS_MIN_E = ~POS_MAX_E;

	logic signed [POS_WIDTH-1:0] pos_x_q, pos_y_q;
	logic signed [POS_WIDTH-1:0] min_x_q, max_x_q, min_y_q, max_y_q;
	logic signed [POS_WIDTH-1:0] from_x_q, from_y_q;
	logic                        out_valid_q, drew_q;

	logic                        take;
	op_kind_t                    kind;
	logic                        neg_x, neg_y;
	logic [STEP_W-1:0]           mag_x, mag_y;
	logic signed [SW-1:0]        ext_px, ext_py, ext_mx, ext_my, sum_x, sum_y;
	logic signed [POS_WIDTH-1:0] new_x, new_y;

	assign take  = !q_empty && (!out_valid_q || out_ready);
	assign q_pop = take;

	always_comb begin
		kind   = op_kind_t'(q_data[2*STEP_W+3 -: 2]);
		neg_x  = q_data[2*STEP_W+1];
		mag_x  = q_data[STEP_W+1 +: STEP_W];
		neg_y  = q_data[STEP_W];
		mag_y  = q_data[STEP_W-1:0];
		ext_px = SW'(pos_x_q);
		ext_py = SW'(pos_y_q);
		ext_mx = SW'(mag_x);
		ext_my = SW'(mag_y);
		sum_x  = neg_x ? ext_px - ext_mx : ext_px + ext_mx;
		sum_y  = neg_y ? ext_py - ext_my : ext_py + ext_my;
		if (sum_x > POS_MAX_E) begin
			new_x = POS_MAX_E[POS_WIDTH-1:0];
		end else if (sum_x < POS_MIN_E) begin
			new_x = POS_MIN_E[POS_WIDTH-1:0];
		end else begin
			new_x = sum_x[POS_WIDTH-1:0];
		end
		if (sum_y > POS_MAX_E) begin
			new_y = POS_MAX_E[POS_WIDTH-1:0];
		end else if (sum_y < POS_MIN_E) begin
			new_y = POS_MIN_E[POS_WIDTH-1:0];
		end else begin
			new_y = sum_y[POS_WIDTH-1:0];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
			drew_q      <= 1'b0;
			pos_x_q     <= '0;
			pos_y_q     <= '0;
			min_x_q     <= '0;
			max_x_q     <= '0;
			min_y_q     <= '0;
			max_y_q     <= '0;
		end else if (take) begin
			out_valid_q <= 1'b1;
			drew_q      <= (kind == OP_MOVE);
			case (kind)
				OP_RESTART: begin
					pos_x_q <= start_x;
					pos_y_q <= start_y;
					min_x_q <= start_x;
					max_x_q <= start_x;
					min_y_q <= start_y;
					max_y_q <= start_y;
				end
				OP_MOVE: begin
					pos_x_q <= new_x;
					pos_y_q <= new_y;
					if (new_x < min_x_q) min_x_q <= new_x;
					if (new_x > max_x_q) max_x_q <= new_x;
					if (new_y < min_y_q) min_y_q <= new_y;
					if (new_y > max_y_q) max_y_q <= new_y;
				end
				default: ;
			endcase
		end else if (out_ready) begin
			out_valid_q <= 1'b0;
		end
	end

	// segment start: old position, or the start point on restart
	always_ff @(posedge clk) begin
		if (take) begin
			from_x_q <= (kind == OP_RESTART) ? start_x : pos_x_q;
			from_y_q <= (kind == OP_RESTART) ? start_y : pos_y_q;
		end
	end

	assign out_valid = out_valid_q;
	assign drew      = drew_q;
	assign from_x    = OUT_W'(from_x_q);
	assign from_y    = OUT_W'(from_y_q);
	assign to_x      = OUT_W'(pos_x_q);
	assign to_y      = OUT_W'(pos_y_q);
	assign box_min_x = OUT_W'(min_x_q);
	assign box_max_x = OUT_W'(max_x_q);
	assign box_min_y = OUT_W'(min_y_q);
	assign box_max_y = OUT_W'(max_y_q);

	assert property (@(posedge clk) disable iff (!arst_n)
		(min_x_q <= pos_x_q) && (pos_x_q <= max_x_q) &&
		(min_y_q <= pos_y_q) && (pos_y_q <= max_y_q))
		else $error("position outside bounding box");

	assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid_q && !drew_q) |-> ((from_x_q == pos_x_q) && (from_y_q == pos_y_q)))
		else $error("segment without a move has distinct end points");

endmodule
`default_nettype wire
